/* hw/rtl/msqw_pkg.sv */
// shared types and constants of the multi-server queue wait unit
// no dependencies
`default_nettype none

package msqw_pkg;

    localparam int MAX_SERVERS_DEF = 16;
    localparam int CFG_W           = 5;
    localparam int ARRIVAL_W       = 20;
    localparam int DURATION_W      = 16;
    localparam int TIME_W          = 32;
    localparam int IN_DATA_W       = 40;
    localparam int OUT_DATA_W      = 96;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FINISH,
        ST_DONE
    } msqw_state_t;

endpackage

`default_nettype wire

/* hw/rtl/msqw_sat_add.sv */
// 32-bit unsigned adder that saturates at all ones
// depends on msqw_pkg
`default_nettype none

module msqw_sat_add
(
    input  wire logic [msqw_pkg::TIME_W-1:0] a,
    input  wire logic [msqw_pkg::TIME_W-1:0] b,
    output logic      [msqw_pkg::TIME_W-1:0] sum
);
    import msqw_pkg::*;

    logic [TIME_W:0] raw;

    assign raw = {1'b0, a} + {1'b0, b};
    // carry out means the true sum does not fit
    assign sum = raw[TIME_W] ? {TIME_W{1'b1}} : raw[TIME_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/multi_server_queue_wait_unit.sv */
// multi-server first-come queue: per job wait, start time and running wait total
// depends on msqw_pkg and msqw_sat_add
// free server: accept, ST_FINISH, ST_DONE; all servers busy (busy = busy server count,
//   at most MAX_SERVERS): ST_SCAN, one finish time per cycle, ST_DECIDE, ST_FINISH, ST_DONE
// jobs do not overlap: a new one is taken only in ST_IDLE, after ST_DONE has moved the
//   last result into a free output register, so an unread result holds off the next job
// reset: server_count returns to 1, no busy servers, wait total zero, no result
//   pending; the finish-time memory is not cleared (only written entries are read)
`default_nettype none

module multi_server_queue_wait_unit
#(
    parameter int MAX_SERVERS = msqw_pkg::MAX_SERVERS_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration: server_count
    input  wire logic                              cfg_wr_en,
    input  wire logic [msqw_pkg::CFG_W-1:0]        cfg_wr_data,
    // input word
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [19:0] arrival_time, [35:20] job_duration, [39:36] zero
    input  wire logic [msqw_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] first_of_run
    input  wire logic                              s_tuser,
    // result word
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] job_wait, [63:32] start_time, [95:64] total_wait
    output logic      [msqw_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import msqw_pkg::*;

    localparam int ADDR_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int IDX_W  = $clog2(MAX_SERVERS + 1);

    // control state
    msqw_state_t        state_reg,    state_next;
    logic [CFG_W-1:0]   cfg_reg;
    logic [IDX_W-1:0]   busy_reg,     busy_next;
    logic [TIME_W-1:0]  sum_reg,      sum_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               data_vld_reg, data_vld_next;
    logic               out_vld_reg,  out_vld_next;

    // job payload
    logic [ARRIVAL_W-1:0]  arrival_reg,  arrival_next;
    logic [DURATION_W-1:0] duration_reg, duration_next;
    logic [TIME_W-1:0]     start_reg,    start_next;
    logic [TIME_W-1:0]     wait_reg,     wait_next;
    logic [ADDR_W-1:0]     wr_idx_reg,   wr_idx_next;
    logic [ADDR_W-1:0]     data_idx_reg, data_idx_next;
    logic [TIME_W-1:0]     best_val_reg, best_val_next;
    logic [ADDR_W-1:0]     best_idx_reg, best_idx_next;

    // output register
    logic [TIME_W-1:0] out_wait_reg,  out_wait_next;
    logic [TIME_W-1:0] out_start_reg, out_start_next;
    logic [TIME_W-1:0] out_total_reg, out_total_next;

    // finish-time memory, one read and one write port
    logic [TIME_W-1:0] finish_mem [MAX_SERVERS];
    logic [TIME_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [TIME_W-1:0] wr_data;

    // derived values
    logic [IDX_W-1:0]      servers_eff;
    logic [IDX_W-1:0]      busy_eff;
    logic [TIME_W-1:0]     finish_sum;
    logic [TIME_W-1:0]     total_sum;
    logic [ARRIVAL_W-1:0]  in_arrival;
    logic [DURATION_W-1:0] in_duration;

    assign in_arrival  = s_tdata[ARRIVAL_W-1:0];
    assign in_duration = s_tdata[ARRIVAL_W+DURATION_W-1:ARRIVAL_W];

    // clamp the configured count into 1..MAX_SERVERS
    always_comb
    begin
        priority if (cfg_reg == '0)
        begin
            servers_eff = IDX_W'(1);
        end
        else if (int'(cfg_reg) >= MAX_SERVERS)
        begin
            servers_eff = IDX_W'(MAX_SERVERS);
        end
        else
        begin
            servers_eff = IDX_W'(cfg_reg);
        end
    end

    // a new run starts with no busy server
    assign busy_eff = s_tuser ? '0 : busy_reg;

    // new finish time of the chosen server
    msqw_sat_add u_finish_add
    (
        .a   (start_reg),
        .b   ({{(TIME_W-DURATION_W){1'b0}}, duration_reg}),
        .sum (finish_sum)
    );

    // running wait total
    msqw_sat_add u_total_add
    (
        .a   (sum_reg),
        .b   (wait_reg),
        .sum (total_sum)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        sum_next       = sum_reg;
        scan_idx_next  = scan_idx_reg;
        data_vld_next  = 1'b0;
        out_vld_next   = out_vld_reg && !m_tready;
        arrival_next   = arrival_reg;
        duration_next  = duration_reg;
        start_next     = start_reg;
        wait_next      = wait_reg;
        wr_idx_next    = wr_idx_reg;
        data_idx_next  = data_idx_reg;
        best_val_next  = best_val_reg;
        best_idx_next  = best_idx_reg;
        out_wait_next  = out_wait_reg;
        out_start_next = out_start_reg;
        out_total_next = out_total_reg;
        s_tready       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = scan_idx_reg[ADDR_W-1:0];
        wr_en          = 1'b0;
        wr_data        = finish_sum;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    arrival_next  = in_arrival;
                    duration_next = in_duration;
                    busy_next     = busy_eff;
                    if (s_tuser)
                    begin
                        sum_next = '0;
                    end
                    if (busy_eff < servers_eff)
                    begin
                        // free server: start on arrival
                        start_next  = {{(TIME_W-ARRIVAL_W){1'b0}}, in_arrival};
                        wait_next   = '0;
                        wr_idx_next = busy_eff[ADDR_W-1:0];
                        busy_next   = busy_eff + IDX_W'(1);
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // read issue, one entry per cycle
                if (scan_idx_reg < busy_reg)
                begin
                    rd_en         = 1'b1;
                    data_idx_next = scan_idx_reg[ADDR_W-1:0];
                    data_vld_next = 1'b1;
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
                // compare the entry read last cycle, lowest index wins ties
                if (data_vld_reg)
                begin
                    if ((data_idx_reg == '0) || (rd_data_reg < best_val_reg))
                    begin
                        best_val_next = rd_data_reg;
                        best_idx_next = data_idx_reg;
                    end
                    if (IDX_W'(data_idx_reg) == (busy_reg - IDX_W'(1)))
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                wr_idx_next = best_idx_reg;
                if ({{(TIME_W-ARRIVAL_W){1'b0}}, arrival_reg} < best_val_reg)
                begin
                    start_next = best_val_reg;
                    wait_next  = best_val_reg - {{(TIME_W-ARRIVAL_W){1'b0}}, arrival_reg};
                end
                else
                begin
                    start_next = {{(TIME_W-ARRIVAL_W){1'b0}}, arrival_reg};
                    wait_next  = '0;
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                wr_en      = 1'b1;
                sum_next   = total_sum;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // hand over once the output register is free
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next   = 1'b1;
                    out_wait_next  = wait_reg;
                    out_start_next = start_reg;
                    out_total_next = sum_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= CFG_W'(1);
            busy_reg     <= '0;
            sum_reg      <= '0;
            scan_idx_reg <= '0;
            data_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            busy_reg     <= busy_next;
            sum_reg      <= sum_next;
            scan_idx_reg <= scan_idx_next;
            data_vld_reg <= data_vld_next;
            out_vld_reg  <= out_vld_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        arrival_reg   <= arrival_next;
        duration_reg  <= duration_next;
        start_reg     <= start_next;
        wait_reg      <= wait_next;
        wr_idx_reg    <= wr_idx_next;
        data_idx_reg  <= data_idx_next;
        best_val_reg  <= best_val_next;
        best_idx_reg  <= best_idx_next;
        out_wait_reg  <= out_wait_next;
        out_start_reg <= out_start_next;
        out_total_reg <= out_total_next;
    end

    // finish-time memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            finish_mem[wr_idx_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= finish_mem[rd_addr];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_total_reg, out_start_reg, out_wait_reg};

`ifndef SYNTHESIS
    // never more busy servers than exist
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(busy_reg) <= MAX_SERVERS)
    else $error("busy count above server limit");

    // a scan only runs with at least one busy server to look at
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (busy_reg != '0))
    else $error("scan with no busy server");

    // a job never starts before it arrives
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |->
            (start_reg >= {{(TIME_W-ARRIVAL_W){1'b0}}, arrival_reg}))
    else $error("start before arrival");

    // wait matches start minus arrival
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |->
            (wait_reg == (start_reg - {{(TIME_W-ARRIVAL_W){1'b0}}, arrival_reg})))
    else $error("wait inconsistent with start time");
`endif

endmodule

`default_nettype wire

/* test/tb_multi_server_queue_wait_unit.sv */
// self-checking testbench for multi_server_queue_wait_unit: directed jobs, then random job runs
// under several server counts, checked against a built-in queue predictor
// depends on msqw_pkg and the multi_server_queue_wait_unit rtl
`default_nettype none

module tb_multi_server_queue_wait_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import msqw_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 400000;
    // long enough to cover the longest busy scan of any job in flight
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_IDLE      = 18;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 500;
    localparam int REPORT_MAX    = 10;
    localparam int ARRIVAL_MAX   = (1 << ARRIVAL_W) - 1;
    localparam int PHASE_COUNT   = 9;
    localparam int PHASE_JOBS    = 115;

    // result word layout, lowest field last in the packed struct
    typedef struct packed
    {
        logic [TIME_W-1:0] total_wait;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] job_wait;
    } job_result_t;

    // predictor of the queue plus the store of results still owed by the block
    class queue_wait_scoreboard;
        logic [TIME_W-1:0] finish_at [MAX_SERVERS_DEF];
        int unsigned       busy;
        logic [TIME_W-1:0] wait_total;
        logic [CFG_W-1:0]  server_cfg;
        job_result_t       owed_q [$];
        int                errors;
        int                reported;

        function new();
            foreach (finish_at[i])
                finish_at[i] = '0;
            busy       = 0;
            wait_total = '0;
            server_cfg = CFG_W'(1);
            errors     = 0;
            reported   = 0;
        endfunction

        function logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
            logic [TIME_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
        endfunction

        function void set_servers(logic [CFG_W-1:0] value);
            server_cfg = value;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // accepted job word: advance the queue and remember the result it owes
        function void note_job(bit first, logic [ARRIVAL_W-1:0] arrival,
                               logic [DURATION_W-1:0] duration);
            int unsigned servers;
            int unsigned best;
            int unsigned i;
            job_result_t r;
            // count of 0 acts as one server, anything above the array size is clamped
            if (server_cfg == 0)
                servers = 1;
            else if (server_cfg > MAX_SERVERS_DEF)
                servers = MAX_SERVERS_DEF;
            else
                servers = server_cfg;
            if (first)
            begin
                busy       = 0;
                wait_total = '0;
            end
            r.job_wait   = '0;
            r.start_time = TIME_W'(arrival);
            if (busy < servers)
            begin
                finish_at[busy] = sat_add(TIME_W'(arrival), TIME_W'(duration));
                busy++;
            end
            else
            begin
                // earliest finisher among all busy entries, lowest index on ties
                best = 0;
                for (i = 1; i < busy; i++)
                    if (finish_at[i] < finish_at[best])
                        best = i;
                if (TIME_W'(arrival) < finish_at[best])
                begin
                    r.start_time = finish_at[best];
                    r.job_wait   = finish_at[best] - TIME_W'(arrival);
                    wait_total   = sat_add(wait_total, r.job_wait);
                end
                finish_at[best] = sat_add(r.start_time, TIME_W'(duration));
            end
            r.total_wait = wait_total;
            owed_q.insert(owed_q.size(), r);
        endfunction

        function void compare_field(string name, logic [TIME_W-1:0] want,
                                    logic [TIME_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                if (reported < REPORT_MAX)
                begin
                    reported++;
                    $display("mismatch %s: expected %0d, got %0d", name, want, got);
                end
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] word);
            job_result_t got;
            job_result_t want;
            got = word;
            if (owed_q.size() == 0)
            begin
                errors++;
                if (reported < REPORT_MAX)
                begin
                    reported++;
                    $display("result word %h with no job outstanding", word);
                end
                return;
            end
            want = owed_q.pop_front();
            compare_field("job_wait", want.job_wait, got.job_wait);
            compare_field("start_time", want.start_time, got.start_time);
            compare_field("total_wait", want.total_wait, got.total_wait);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;

    queue_wait_scoreboard   sb;
    int                     jobs_sent;
    int                     results_seen;
    int                     cycle_count;

    multi_server_queue_wait_unit DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run guard: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one job word: random gap (none inside calm stretches), then hold until accepted
    task automatic send_job(bit first, logic [ARRIVAL_W-1:0] arrival,
                            logic [DURATION_W-1:0] duration);
        int gap;
        gap = ((jobs_sent % 256) < 40) ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({duration, arrival});
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_job(first, arrival, duration);
        jobs_sent++;
    endtask

    // stop offering, let every owed result come back, then let the block go quiet
    task automatic drain_jobs();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register writes happen only with the block idle
    task automatic write_server_count(logic [CFG_W-1:0] value);
        drain_jobs();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        sb.set_servers(value);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic directed_jobs();
        // single server from reset: shortest and longest durations, arrival extremes
        send_job(1'b1, '0, 16'd1);
        send_job(1'b0, '0, 16'hFFFF);
        send_job(1'b0, 20'hFFFFF, 16'hFFFF);
        send_job(1'b0, 20'hFFFFF, 16'd1);
        // three servers: free servers first, then a tie for earliest finish,
        // a job arriving after all servers are done and one arriving exactly at a finish
        write_server_count(CFG_W'(3));
        send_job(1'b1, 20'd10, 16'd100);
        send_job(1'b0, 20'd10, 16'd100);
        send_job(1'b0, 20'd10, 16'd100);
        send_job(1'b0, 20'd10, 16'd5);
        send_job(1'b0, 20'd500, 16'd7);
        send_job(1'b0, 20'd115, 16'd3);
        // lowered while three servers are still busy
        write_server_count(CFG_W'(2));
        send_job(1'b0, 20'd120, 16'd50);
        send_job(1'b0, 20'd120, 16'd50);
        // count of zero behaves as one server, plus a decreasing arrival
        write_server_count(CFG_W'(0));
        send_job(1'b1, 20'd5, 16'd10);
        send_job(1'b0, 20'd5, 16'd10);
        send_job(1'b0, 20'd4, 16'd2);
        // top of the register range clamps to the full server array
        write_server_count(CFG_W'(31));
        send_job(1'b1, 20'd7, 16'd30);
        send_job(1'b0, 20'd7, 16'd30);
        send_job(1'b0, 20'd8, 16'd30);
    endtask

    // mostly well-formed runs (nondecreasing arrivals, random content), some noise words
    task automatic random_phase(int n_jobs, bit clear_at_start);
        int left;
        int arr;
        int dur_max;
        int step_max;
        int k;
        bit first;
        left     = 0;
        arr      = 0;
        dur_max  = 1;
        step_max = 0;
        for (k = 0; k < n_jobs; k++)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                // noise: any arrival, random run flag, any nonzero duration
                send_job(1'($urandom_range(0, 1)), ARRIVAL_W'($urandom),
                         DURATION_W'($urandom_range(1, 65535)));
            end
            else
            begin
                first = 1'b0;
                if (left == 0)
                begin
                    left  = $urandom_range(4, 80);
                    first = (k > 0) || clear_at_start;
                    if ($urandom_range(0, 9) == 0)
                        arr = ARRIVAL_MAX - int'($urandom_range(0, 2000));
                    else
                        arr = $urandom_range(0, ARRIVAL_MAX);
                    case ($urandom_range(0, 3))
                        0: dur_max = 8;
                        1: dur_max = 64;
                        2: dur_max = 1000;
                        default: dur_max = 65535;
                    endcase
                    // tight arrivals give long queues, loose ones leave servers idle
                    step_max = dur_max / int'($urandom_range(1, 16));
                end
                send_job(first, ARRIVAL_W'(arr), DURATION_W'($urandom_range(1, dur_max)));
                arr = arr + int'($urandom_range(0, step_max));
                if (arr > ARRIVAL_MAX)
                    arr = ARRIVAL_MAX;
                left--;
            end
        end
    endtask

    // result side: random stall per word, calm stretches, and one long hold-off
    // that backs the block up into its input
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (results_seen == HOLD_AT)
                stall = HOLD_CYCLES;
            else if ((results_seen % 290) < 50)
                stall = 0;
            else
                stall = $urandom_range(0, MAX_IDLE);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(m_tdata);
            results_seen++;
        end
    end

    initial
    begin
        logic [CFG_W-1:0] phase_servers [PHASE_COUNT];
        bit               phase_clear   [PHASE_COUNT];
        int               p;
        phase_servers = '{CFG_W'(16), CFG_W'(2), CFG_W'(0), CFG_W'(5), CFG_W'(1),
                          CFG_W'(31), CFG_W'(17), CFG_W'(8), CFG_W'($urandom_range(0, 31))};
        // phases that keep the previous state carry it into the new count, mostly lowered mid-run
        phase_clear   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        sb           = new();
        jobs_sent    = 0;
        results_seen = 0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_jobs();
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            write_server_count(phase_servers[p]);
            random_phase(PHASE_JOBS, phase_clear[p]);
        end

        drain_jobs();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
